// ===== sv/spq_pkg.sv =====
// shared types and constants for the sorted insert priority queue
`timescale 1ns / 1ps
package spq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int PRI_W = 8;
  localparam int ID_W = 16;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic             mode;
    logic [PRI_W-1:0] new_priority;
    logic [ID_W-1:0]  new_id;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  out_id;
    logic [PRI_W-1:0] out_priority;
  } out_t;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_t;

  // broadcast to every cell in the row
  typedef struct packed {
    cell_op_t op;
    entry_t   ins;
  } cell_ctrl_t;

endpackage

// ===== sv/sorted_insert_priority_queue.sv =====
// top level: bounded priority queue built as a row of shifting slot cells
`timescale 1ns / 1ps
// Usage
//   Pulse start with in_data for one beat. mode 0 enqueues (new_priority,
//   new_id); mode 1 removes the head, the oldest entry of highest priority.
//   busy stays low: a beat is taken in every cycle that start is high.
//   In the cycle after acceptance out_valid is high for one cycle with
//   out_data: status enqueued, full (rejected, queue unchanged), dequeued
//   (out_id/out_priority hold the head) or empty. Non-dequeue results carry
//   zero id and priority.
//   Throughput is one beat per cycle: every cell compares its slot with the
//   new priority and moves its entry one place in the same cycle, so the
//   slot row updates at the next edge.
//   The receiver cannot stall; results must be taken when shown.
//   Reset clears the occupancy count and the result strobe; slot contents
//   are left as they are and only slots below the count are ever used.
module sorted_insert_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::in_t  in_data,
  output logic          out_valid,
  output spq_pkg::out_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  spq_pkg::out_t out_data_r;
  spq_pkg::out_t out_data_nxt;

  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     entries [CAPACITY];
  logic [CAPACITY-1:0] keeps;

  logic accept;
  logic is_full;
  logic is_empty;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);

  always_comb begin
    ctrl.op            = spq_pkg::OP_HOLD;
    ctrl.ins.pri       = in_data.new_priority;
    ctrl.ins.id        = in_data.new_id;
    count_nxt          = count_r;
    out_data_nxt       = '0;
    out_data_nxt.status = spq_pkg::ST_EMPTY;
    if (accept) begin
      if (in_data.mode == spq_pkg::MODE_ENQ) begin
        if (is_full) begin
          out_data_nxt.status = spq_pkg::ST_FULL;
        end else begin
          ctrl.op             = spq_pkg::OP_INSERT;
          count_nxt           = count_r + CW'(1);
          out_data_nxt.status = spq_pkg::ST_ENQUEUED;
        end
      end else begin
        if (!is_empty) begin
          ctrl.op                   = spq_pkg::OP_REMOVE;
          count_nxt                 = count_r - CW'(1);
          out_data_nxt.status       = spq_pkg::ST_DEQUEUED;
          out_data_nxt.out_id       = entries[0].id;
          out_data_nxt.out_priority = entries[0].pri;
        end
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t prev_e;
    spq_pkg::entry_t next_e;
    logic            prev_k;
    if (i == 0) begin : g_first
      assign prev_e = ctrl.ins;
      assign prev_k = 1'b0;
    end else begin : g_mid
      assign prev_e = entries[i-1];
      assign prev_k = keeps[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_e = entries[i];
    end else begin : g_body
      assign next_e = entries[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .live       (CW'(i) < count_r),
      .prev_keep  (prev_k),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .keep       (keeps[i]),
      .entry      (entries[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted beat gave no result");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.mode == spq_pkg::MODE_ENQ && !is_full
    |=> count_r == $past(count_r) + CW'(1))
    else $error("enqueue did not grow the queue");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != spq_pkg::ST_DEQUEUED
    |-> out_data.out_id == '0 && out_data.out_priority == '0)
    else $error("non-dequeue result carries an entry");

endmodule

// ===== sv/spq_cell.sv =====
// one slot of the sorted row: holds an entry and shifts toward its neighbors
`timescale 1ns / 1ps
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               live,
  input  logic               prev_keep,
  input  spq_pkg::entry_t    prev_entry,
  input  spq_pkg::entry_t    next_entry,
  output logic               keep,
  output spq_pkg::entry_t    entry
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // an occupied slot of equal or higher priority stays in place
  assign keep  = live && (entry_r.pri >= ctrl.ins.pri);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctrl.op)
      spq_pkg::OP_HOLD: entry_nxt = entry_r;
      spq_pkg::OP_INSERT: begin
        if (keep) begin
          entry_nxt = entry_r;
        end else if (prev_keep) begin
          entry_nxt = ctrl.ins;
        end else begin
          entry_nxt = prev_entry;
        end
      end
      spq_pkg::OP_REMOVE: entry_nxt = next_entry;
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== dv/sorted_insert_priority_queue_tb.sv =====
// testbench for the sorted insert priority queue: directed and random beats vs a predictor
`timescale 1ns / 1ps
module sorted_insert_priority_queue_tb;

  localparam int CAP = spq_pkg::CAPACITY_DEF;
  localparam int PRI_W = spq_pkg::PRI_W;
  localparam int ID_W = spq_pkg::ID_W;
  localparam int CYCLE_LIMIT = 100000;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  spq_pkg::in_t in_data;
  logic out_valid;
  spq_pkg::out_t out_data;

  // predicted queue contents, head at index 0
  spq_pkg::entry_t shadow_row[CAP];
  int shadow_held = 0;
  spq_pkg::out_t pending_replies[$];

  int mismatches = 0;
  int cycle_count = 0;
  int sender_idle_pct;

  sorted_insert_priority_queue dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_insert_priority_queue: mismatch");
      $finish;
    end
  end

  // apply one request to the predicted queue and return the reply it earns
  function automatic spq_pkg::out_t serve_request(input spq_pkg::in_t req);
    spq_pkg::out_t rsp;
    int pos;
    int k;
    rsp = '0;
    if (req.mode == spq_pkg::MODE_ENQ) begin
      if (shadow_held >= CAP) begin
        rsp.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        // equal priorities stay in arrival order
        while (pos < shadow_held && shadow_row[pos].pri >= req.new_priority) pos++;
        for (k = shadow_held; k > pos; k--) shadow_row[k] = shadow_row[k-1];
        shadow_row[pos].pri = req.new_priority;
        shadow_row[pos].id = req.new_id;
        shadow_held++;
        rsp.status = spq_pkg::ST_ENQUEUED;
      end
    end else begin
      if (shadow_held == 0) begin
        rsp.status = spq_pkg::ST_EMPTY;
      end else begin
        rsp.out_id = shadow_row[0].id;
        rsp.out_priority = shadow_row[0].pri;
        for (k = 1; k < shadow_held; k++) shadow_row[k-1] = shadow_row[k];
        shadow_held--;
        rsp.status = spq_pkg::ST_DEQUEUED;
      end
    end
    return rsp;
  endfunction

  task automatic flag_mismatch(input string what, input spq_pkg::out_t want,
                               input spq_pkg::out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected status %0d id %h pri %h, got status %0d id %h pri %h",
               what, want.status, want.out_id, want.out_priority,
               got.status, got.out_id, got.out_priority);
  endtask

  // compare the reply of the previous beat, then predict the beat taken now
  always @(posedge clk) begin : check_replies
    spq_pkg::out_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (pending_replies.size() == 0) begin
          flag_mismatch("reply with none pending", '0, out_data);
        end else begin
          want = pending_replies.pop_front();
          if (out_data.status !== want.status || out_data.out_id !== want.out_id ||
              out_data.out_priority !== want.out_priority)
            flag_mismatch("reply differs", want, out_data);
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        pending_replies.push_back(serve_request(in_data));
    end
  end

  function automatic spq_pkg::in_t make_beat(input logic mode, input logic [PRI_W-1:0] pri,
                                             input logic [ID_W-1:0] id);
    spq_pkg::in_t b;
    b.mode = mode;
    b.new_priority = pri;
    b.new_id = id;
    return b;
  endfunction

  // hold one beat on the input until it is taken, idling each cycle with the set odds
  task automatic send_beat(input spq_pkg::in_t beat);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      in_data = make_beat(1'($urandom), PRI_W'($urandom), ID_W'($urandom));
    end
    @(negedge clk);
    start = 1'b1;
    in_data = beat;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic test_directed();
    sender_idle_pct = 0;
    send_beat(make_beat(spq_pkg::MODE_DEQ, 8'hff, 16'hffff));  // empty queue, fields ignored
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'd0, 16'h0000));
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'd255, 16'hffff));
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'd128, 16'h1111));
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'd128, 16'h2222));  // tie keeps arrival order
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'd255, 16'h3333));
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'd0, 16'h4444));
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'd128, 16'h5555));
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'd1, 16'h8001));
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'd254, 16'h7ffe));
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'h55, 16'haaaa));
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'haa, 16'h5555));
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'd128, 16'h6666));
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'd64, 16'h0001));
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'd192, 16'h8000));
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'd2, 16'h00ff));
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'd250, 16'hff00));  // sixteenth entry fills it
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'd255, 16'hbeef));  // rejected, though no entry outranks it
    send_beat(make_beat(spq_pkg::MODE_DEQ, 8'h5a, 16'hc3c3));
    send_beat(make_beat(spq_pkg::MODE_ENQ, 8'd100, 16'h1234));  // freed slot reused
    send_beat(make_beat(spq_pkg::MODE_DEQ, 8'd0, 16'h0000));
    send_beat(make_beat(spq_pkg::MODE_DEQ, 8'd0, 16'h0000));
  endtask

  // random traffic; the enqueue share drifts so the fill level sweeps empty to full
  task automatic test_random_traffic(input int beats, input int idle_pct);
    int enq_pct;
    int n;
    logic [PRI_W-1:0] pri;
    sender_idle_pct = idle_pct;
    enq_pct = 50;
    for (n = 0; n < beats; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 20;
          1: enq_pct = 50;
          default: enq_pct = 80;
        endcase
      end
      case ($urandom_range(9))
        0, 1, 2, 3: pri = PRI_W'($urandom_range(0, 3));  // many ties
        4: pri = 8'd0;
        5: pri = 8'd255;
        default: pri = PRI_W'($urandom_range(0, 255));
      endcase
      send_beat(make_beat(($urandom_range(99) < enq_pct) ? spq_pkg::MODE_ENQ
                                                         : spq_pkg::MODE_DEQ,
                          pri, ID_W'($urandom_range(0, 16'hffff))));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    sender_idle_pct = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_traffic(480, 0);
    test_random_traffic(480, 48);
    test_random_traffic(480, 36);

    @(negedge clk);
    start = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0)
      $display("sorted_insert_priority_queue: match");
    else
      $display("sorted_insert_priority_queue: mismatch");
    $finish;
  end

endmodule
